[rtl/idl_pkg.sv]
// idl_pkg: shared types and constants of the indexed deque list
// holds sizes, action and status codes and the cell operation struct
// no dependencies
package idl_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int POS_W      = 5;
    localparam int STAT_W     = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_INSERT     = 3'd4,
        ACT_DELETE     = 3'd5,
        ACT_GET        = 3'd6,
        ACT_CLEAR      = 3'd7
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // what the cell array does for one request
    typedef struct packed {
        logic             en;
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
        logic             rd;
        logic [IDX_W-1:0] rd_idx;
    } t_cell_op;

endpackage

[rtl/idl_if.sv]
// idl_req_if and idl_rsp_if: valid/ready channels of the indexed deque list
// depends on idl_pkg
interface idl_req_if;
    logic                        valid;
    logic                        ready;
    logic [idl_pkg::ACT_W-1:0]   action;
    logic [idl_pkg::POS_W-1:0]   position;
    logic [idl_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

interface idl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [idl_pkg::DATA_WIDTH-1:0] data_out;
    logic [idl_pkg::STAT_W-1:0]  status;
    logic [idl_pkg::CNT_W-1:0]   count;

    modport source (output valid, data_out, status, count, input ready);
    modport sink   (input valid, data_out, status, count, output ready);
endinterface

[rtl/idl_ctrl.sv]
// idl_ctrl: decodes one request against the current count
// gives status, next count and the cell operation; depends on idl_pkg
module idl_ctrl (
    input  logic                      i_en,
    input  logic [idl_pkg::ACT_W-1:0] i_action,
    input  logic [idl_pkg::POS_W-1:0] i_position,
    input  logic [idl_pkg::CNT_W-1:0] i_count,
    output logic [idl_pkg::STAT_W-1:0] o_status,
    output logic [idl_pkg::CNT_W-1:0] o_count,
    output idl_pkg::t_cell_op         o_op
);
    import idl_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    t_status          w_status;
    t_cell_op         w_op;
    logic [CNT_W-1:0] w_count;
    logic [CNT_W-1:0] w_last;

    assign w_last = i_count - ONE;

    always_comb begin
        w_status  = ST_OK;
        w_count   = i_count;
        w_op      = '0;
        w_op.en   = i_en;
        unique case (t_action'(i_action))
            ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                if (i_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    w_op.pos = (t_action'(i_action) == ACT_PUSH_BACK) ?
                               i_count[IDX_W-1:0] : '0;
                    w_count  = i_count + ONE;
                end
            end
            ACT_POP_BACK, ACT_POP_FRONT: begin
                if (i_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op.rd  = 1'b1;
                    // pop back reads the tail and leaves the cells in place
                    if (t_action'(i_action) == ACT_POP_BACK) begin
                        w_op.rd_idx = w_last[IDX_W-1:0];
                    end else begin
                        w_op.rd_idx = '0;
                        w_op.del    = 1'b1;
                        w_op.pos    = '0;
                    end
                    w_count = w_last;
                end
            end
            ACT_INSERT: begin
                if (CNT_W'(i_position) > i_count) begin
                    w_status = ST_BADIDX;
                end else if (i_count == FULL_CNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_op.ins = 1'b1;
                    w_op.pos = i_position[IDX_W-1:0];
                    w_count  = i_count + ONE;
                end
            end
            ACT_DELETE: begin
                if (CNT_W'(i_position) >= i_count) begin
                    w_status = ST_BADIDX;
                end else begin
                    w_op.del = 1'b1;
                    w_op.pos = i_position[IDX_W-1:0];
                    w_count  = w_last;
                end
            end
            ACT_GET: begin
                if (CNT_W'(i_position) >= i_count) begin
                    w_status = ST_BADIDX;
                end else begin
                    w_op.rd     = 1'b1;
                    w_op.rd_idx = i_position[IDX_W-1:0];
                end
            end
            ACT_CLEAR: begin
                w_count = '0;
            end
            default: begin
                w_count = i_count;
            end
        endcase
    end

    assign o_status = w_status;
    assign o_count  = w_count;
    assign o_op     = w_op;

endmodule

[rtl/idl_cells.sv]
// idl_cells: row of data cells, each shifts left, shifts right, loads or holds
// one read port for pop and get; depends on idl_pkg
module idl_cells (
    input  logic                           i_clk,
    input  idl_pkg::t_cell_op              i_op,
    input  logic [idl_pkg::DATA_WIDTH-1:0] i_value,
    output logic [idl_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import idl_pkg::*;

    logic [DATA_WIDTH-1:0] r_cell [DEPTH];

    // read sees the contents before this request updates them
    assign o_rd_data = i_op.rd ? r_cell[i_op.rd_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i_op.ins && IDX_W'(i) == i_op.pos) begin
                    r_cell[i] <= i_value;
                end else if (i_op.ins && IDX_W'(i) > i_op.pos && i > 0) begin
                    r_cell[i] <= r_cell[(i > 0) ? i - 1 : 0];
                end else if (i_op.del && IDX_W'(i) >= i_op.pos && i < DEPTH - 1) begin
                    r_cell[i] <= r_cell[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

endmodule

[rtl/indexed_deque_list_unit.sv]
// indexed_deque_list_unit: top level of the bounded indexed deque
// request register, idl_ctrl decode, idl_cells storage, response register
// depends on idl_pkg, idl_if, idl_ctrl, idl_cells
//
//   port     dir  carries
//   i_req    in   action, position, value
//   o_rsp    out  data_out, status, count
//
// a request waits in the request register, is decoded as it moves on and is
// answered from the response register; one request a cycle while o_rsp is ready
// every action, shifts included, completes as the request moves on: all cells
// move in parallel
// reset clears the count and both valid flags, cell contents are not cleared
// a stalled response holds the pipe; ready goes low only when both stages hold
module indexed_deque_list_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idl_req_if.sink    i_req,
    idl_rsp_if.source  o_rsp
);
    import idl_pkg::*;

    logic                  r_in_valid;
    logic [ACT_W-1:0]      r_action;
    logic [POS_W-1:0]      r_position;
    logic [DATA_WIDTH-1:0] r_value;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [STAT_W-1:0]     r_status;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_occ;

    logic                  w_adv;
    logic                  w_take;
    logic [STAT_W-1:0]     w_status;
    logic [CNT_W-1:0]      n_occ;
    logic [DATA_WIDTH-1:0] w_rd_data;
    t_cell_op              w_op;

    assign w_adv  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_take = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || w_adv;

    idl_ctrl u_ctrl (
        .i_en       (w_adv),
        .i_action   (r_action),
        .i_position (r_position),
        .i_count    (r_occ),
        .o_status   (w_status),
        .o_count    (n_occ),
        .o_op       (w_op)
    );

    idl_cells u_cells (
        .i_clk     (i_clk),
        .i_op      (w_op),
        .i_value   (r_value),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_occ       <= n_occ;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action   <= i_req.action;
            r_position <= i_req.position;
            r_value    <= i_req.value;
        end
        if (w_adv) begin
            r_data   <= w_rd_data;
            r_status <= w_status;
            r_count  <= n_occ;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.data_out = r_data;
    assign o_rsp.status   = r_status;
    assign o_rsp.count    = r_count;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_status != ST_OK) |=> (r_occ == $past(r_occ)))
        else $error("rejected request changed the count");

    a_reject_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_data == '0))
        else $error("rejected request returned data");

    a_resp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_count == r_occ))
        else $error("response count differs from occupancy");

endmodule
